// ===== rtl/plel_pkg.sv =====
// shared types, constants and helpers for the positional linked list engine
package plel_pkg;

    localparam int CAPACITY = 16;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int LINK_W   = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 8;

    localparam logic [LINK_W-1:0] NIL_SLOT = LINK_W'(CAPACITY);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_ERASE  = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    typedef struct packed {
        logic                    mode;
        logic [POS_W-1:0]        position;
        logic signed [KEY_W-1:0] new_key;
        logic [VAL_W-1:0]        new_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [KEY_W-1:0] removed_key;
        logic [VAL_W-1:0]        removed_value;
        logic [LINK_W-1:0]       entry_count;
        logic                    is_empty;
    } out_item_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [LINK_W-1:0] data;
    } link_wr_t;

    typedef struct packed {
        logic                    en;
        logic [SLOT_W-1:0]       addr;
        logic signed [KEY_W-1:0] key;
        logic [VAL_W-1:0]        value;
    } data_wr_t;

    // a link that is not a slot index is followed as slot 0
    function automatic logic [SLOT_W-1:0] safe_slot(input logic [LINK_W-1:0] s);
        logic [SLOT_W-1:0] r;
        r = (s < NIL_SLOT) ? s[SLOT_W-1:0] : '0;
        return r;
    endfunction

endpackage

// ===== rtl/plel_links.sv =====
// link table: one link per slot, reset to a chain of all slots
module plel_links
    import plel_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic [LINK_W-1:0] rd_data,
    input  link_wr_t          wr
);

    logic [LINK_W-1:0] link_reg [CAPACITY];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // slot i links i+1, the last one links null
            for (int i = 0; i < CAPACITY; i++)
            begin
                link_reg[i] <= LINK_W'(i + 1);
            end
        end
        else if (wr.en)
        begin
            link_reg[wr.addr] <= wr.data;
        end
    end

    assign rd_data = link_reg[rd_addr];

endmodule

// ===== rtl/plel_data_mem.sv =====
// key and value storage, one write and one registered read per cycle
module plel_data_mem
    import plel_pkg::*;
(
    input  logic                    clk,
    input  data_wr_t                wr,
    input  logic                    rd_en,
    input  logic [SLOT_W-1:0]       rd_addr,
    output logic signed [KEY_W-1:0] rd_key,
    output logic [VAL_W-1:0]        rd_value
);

    logic signed [KEY_W-1:0] key_mem [CAPACITY];
    logic [VAL_W-1:0]        value_mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            key_mem[wr.addr]   <= wr.key;
            value_mem[wr.addr] <= wr.value;
        end
        if (rd_en)
        begin
            rd_key   <= key_mem[rd_addr];
            rd_value <= value_mem[rd_addr];
        end
    end

endmodule

// ===== rtl/positional_linked_list_engine.sv =====
// top level: sequencer that walks and patches the linked list, plus result register
//
// usage
//   item channel (item_valid / item_ready / item): one transfer per operation,
//   mode selects insert at a 1-based position or erase at a 1-based position
//   result channel (result_valid / result_ready / result): exactly one transfer
//   per item, carrying status, the erased key and value (zero otherwise),
//   the entry count after the operation and an empty flag
// sequence
//   a rejected item (full, empty, bad position) goes straight to the finish state
//   insert at position 1 allocates the slot and links it as head; erase at position 1
//   moves the head on, then frees the slot; at p > 1, insert allocates and then walks,
//   erase walks at once; the walk follows one link per cycle through the single read
//   port of the link table, then insert links and patches, erase bypasses and frees
//   item_ready is high only while the sequencer is idle
// reset
//   the list is empty, all slots are chained on the free list, no result pending
// stalls
//   a finished result sits in the output register; a new item may be taken
//   meanwhile, and the sequencer holds its next result until the register frees
module positional_linked_list_engine
    import plel_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ALLOC   = 4'd1;
    localparam logic [3:0] S_WALK    = 4'd2;
    localparam logic [3:0] S_ILINK   = 4'd3;
    localparam logic [3:0] S_IPATCH  = 4'd4;
    localparam logic [3:0] S_ETGT    = 4'd5;
    localparam logic [3:0] S_EBYPASS = 4'd6;
    localparam logic [3:0] S_EHEAD   = 4'd7;
    localparam logic [3:0] S_EFREE   = 4'd8;
    localparam logic [3:0] S_FINISH  = 4'd9;

    logic [3:0]              state_reg, state_next;
    logic                    mode_reg, mode_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0]        val_reg, val_next;
    logic [1:0]              status_reg, status_next;
    logic [SLOT_W-1:0]       cursor_reg, cursor_next;
    logic [POS_W-1:0]        remain_reg, remain_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [LINK_W-1:0]       head_reg, head_next;
    logic [LINK_W-1:0]       free_reg, free_next;
    logic [LINK_W-1:0]       count_reg, count_next;
    logic                    result_valid_reg, result_valid_next;
    out_item_t               result_reg, result_next;

    logic [SLOT_W-1:0]       link_rd_addr;
    logic [LINK_W-1:0]       link_rd_data;
    link_wr_t                link_wr;
    data_wr_t                data_wr;
    logic                    data_rd_en;
    logic signed [KEY_W-1:0] data_rd_key;
    logic [VAL_W-1:0]        data_rd_value;

    logic                    accept;
    logic [POS_W:0]          pos_ext;
    logic [POS_W:0]          count_ext;
    logic                    erase_ok;

    plel_links u_links (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data),
        .wr      (link_wr)
    );

    plel_data_mem u_data (
        .clk      (clk),
        .wr       (data_wr),
        .rd_en    (data_rd_en),
        .rd_addr  (slot_reg),
        .rd_key   (data_rd_key),
        .rd_value (data_rd_value)
    );

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // the walk cursor owns the read port while walking and splicing at the predecessor
    assign link_rd_addr = (state_reg == S_WALK || state_reg == S_ILINK ||
                           state_reg == S_ETGT) ? cursor_reg : slot_reg;

    assign pos_ext   = {1'b0, item.position};
    assign count_ext = (POS_W + 1)'(count_reg);
    assign erase_ok  = (mode_reg == MODE_ERASE) && (status_reg == ST_OK);

    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        pos_next          = pos_reg;
        key_next          = key_reg;
        val_next          = val_reg;
        status_next       = status_reg;
        cursor_next       = cursor_reg;
        remain_next       = remain_reg;
        slot_next         = slot_reg;
        head_next         = head_reg;
        free_next         = free_reg;
        count_next        = count_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        link_wr           = '0;
        data_wr           = '0;
        data_rd_en        = 1'b0;

        // result register drains independently of the sequencer
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next   = item.mode;
                    pos_next    = item.position;
                    key_next    = item.new_key;
                    val_next    = item.new_value;
                    cursor_next = safe_slot(head_reg);
                    remain_next = item.position - POS_W'(2);
                    state_next  = S_FINISH;
                    if (item.mode == MODE_INSERT)
                    begin
                        if (count_reg >= LINK_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                        end
                        else if (item.position == '0 || pos_ext > count_ext + 1'b1)
                        begin
                            status_next = ST_BADPOS;
                        end
                        else
                        begin
                            status_next = ST_OK;
                            slot_next   = safe_slot(free_reg);
                            count_next  = count_reg + 1'b1;
                            state_next  = S_ALLOC;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (item.position == '0 || pos_ext > count_ext)
                        begin
                            status_next = ST_BADPOS;
                        end
                        else
                        begin
                            status_next = ST_OK;
                            count_next  = count_reg - 1'b1;
                            if (item.position == POS_W'(1))
                            begin
                                slot_next  = safe_slot(head_reg);
                                state_next = S_EHEAD;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                    end
                end
            end
            S_ALLOC:
            begin
                // take the slot off the free list and store the entry
                free_next     = link_rd_data;
                data_wr.en    = 1'b1;
                data_wr.addr  = slot_reg;
                data_wr.key   = key_reg;
                data_wr.value = val_reg;
                if (pos_reg == POS_W'(1))
                begin
                    link_wr.en   = 1'b1;
                    link_wr.addr = slot_reg;
                    link_wr.data = head_reg;
                    head_next    = {1'b0, slot_reg};
                    state_next   = S_FINISH;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                // cursor ends on the entry before the target position
                if (remain_reg == '0)
                begin
                    state_next = (mode_reg == MODE_INSERT) ? S_ILINK : S_ETGT;
                end
                else
                begin
                    cursor_next = safe_slot(link_rd_data);
                    remain_next = remain_reg - 1'b1;
                end
            end
            S_ILINK:
            begin
                link_wr.en   = 1'b1;
                link_wr.addr = slot_reg;
                link_wr.data = link_rd_data;
                state_next   = S_IPATCH;
            end
            S_IPATCH:
            begin
                link_wr.en   = 1'b1;
                link_wr.addr = cursor_reg;
                link_wr.data = {1'b0, slot_reg};
                state_next   = S_FINISH;
            end
            S_ETGT:
            begin
                slot_next  = safe_slot(link_rd_data);
                state_next = S_EBYPASS;
            end
            S_EBYPASS:
            begin
                // predecessor skips over the erased slot
                link_wr.en   = 1'b1;
                link_wr.addr = cursor_reg;
                link_wr.data = link_rd_data;
                state_next   = S_EFREE;
            end
            S_EHEAD:
            begin
                head_next  = link_rd_data;
                state_next = S_EFREE;
            end
            S_EFREE:
            begin
                // push the erased slot on the free list and fetch its contents
                link_wr.en   = 1'b1;
                link_wr.addr = slot_reg;
                link_wr.data = free_reg;
                free_next    = {1'b0, slot_reg};
                data_rd_en   = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next         = 1'b1;
                    result_next.status        = status_reg;
                    result_next.removed_key   = erase_ok ? data_rd_key : '0;
                    result_next.removed_value = erase_ok ? data_rd_value : '0;
                    result_next.entry_count   = count_reg;
                    result_next.is_empty      = (count_reg == '0);
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            head_reg         <= NIL_SLOT;
            free_reg         <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            free_reg         <= free_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // operation payload, no reset needed
    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        cursor_reg <= cursor_next;
        remain_reg <= remain_next;
        slot_reg   <= slot_next;
        result_reg <= result_next;
    end

    // list never holds more entries than slots
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LINK_W'(CAPACITY))
        else $error("entry count above capacity");

    // count only moves right after a transfer on the item channel
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && !$stable(count_reg)) |-> $past(accept))
        else $error("entry count changed outside an accepted item");

    // leaving the finish state always produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && state_next == S_IDLE) |=> result_valid_reg)
        else $error("finished operation left no result");

    // the walk counts down by one each cycle until it leaves
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && remain_reg != '0) |=>
            (state_reg == S_WALK && remain_reg == $past(remain_reg) - 1'b1))
        else $error("walk counter misstep");

    // an accepted item always starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted item not started");

endmodule
